[hw/rtl/frws_pkg.sv]
// Shared types, constants and helpers for the flash record write sequencer.
`timescale 1ns / 1ps

package frws_pkg;

  localparam int NumFiles   = 32;
  localparam int BlockBytes = 4096;
  localparam int PageBytes  = 256;
  localparam int HdrBytes   = 8;

  localparam int FileW  = $clog2(NumFiles);
  localparam int BlockW = $clog2(BlockBytes);
  localparam int PageW  = $clog2(PageBytes);
  localparam int AddrW  = 18;
  localparam int SizeW  = 12;
  localparam int LenW   = 9;
  localparam int SeqW   = 32;
  localparam int IdxInW = 5;

  localparam int MaxSize = BlockBytes - HdrBytes;

  typedef enum logic [1:0] {
    CmdStart = 2'd0,
    CmdPoll  = 2'd1,
    CmdLoad  = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    OpNone    = 2'd0,
    OpErase   = 2'd1,
    OpProgram = 2'd2
  } flash_op_e;

  typedef enum logic [2:0] {
    PhIdle       = 3'd0,
    PhEraseIssue = 3'd1,
    PhEraseSend  = 3'd2,
    PhEraseWait  = 3'd3,
    PhWriteStart = 3'd4,
    PhWriteSend  = 3'd5,
    PhWriteWait  = 3'd6
  } phase_e;

  typedef struct packed {
    cmd_e              command;
    logic [IdxInW-1:0] file_index;
    logic [SizeW-1:0]  payload_bytes;
    logic              spi_done;
    logic              flash_busy;
    logic              load_slot;
    logic [SeqW-1:0]   load_sequence;
  } in_t;

  typedef struct packed {
    flash_op_e        flash_op;
    logic [AddrW-1:0] flash_address;
    logic [LenW-1:0]  write_length;
    logic [BlockW-1:0] record_offset;
    logic [SeqW-1:0]  header_sequence;
    logic [7:0]       header_checksum;
    logic             sequencer_busy;
    logic             start_rejected;
  } out_t;

  typedef struct packed {
    phase_e           phase;
    logic [FileW-1:0] active_file;
    logic [SizeW-1:0] pending_size;
    logic [AddrW-1:0] page_address;
  } seq_state_t;

  typedef struct packed {
    logic             slot_we;
    logic             seq_we;
    logic [FileW-1:0] idx;
    logic             slot;
    logic [SeqW-1:0]  seq;
  } tbl_wr_t;

  function automatic logic [7:0] header_sum(logic [SeqW-1:0] seq, logic [SizeW-1:0] size);
    logic [7:0] sum;
    sum = seq[7:0] + seq[15:8] + seq[23:16] + seq[31:24] + size[7:0]
        + {4'b0000, size[11:8]};
    return sum;
  endfunction

endpackage

[hw/rtl/flash_record_write_sequencer_core.sv]
// Top level of the flash record write sequencer: request, state and result registers.
// A request is first held in the request register, then its result is registered in the result register.
// Throughput: one request per cycle; the only stall comes from the result side.
// Each request is one step of the sequencer state plus one file table access.
// Reset clears the sequencer to idle and the file table to zero; no clearing pass.
`timescale 1ns / 1ps

module flash_record_write_sequencer_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  frws_pkg::in_t   in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output frws_pkg::out_t  out_data_o
);

  logic                      in_valid_q;
  frws_pkg::in_t             in_data_q;
  logic                      out_valid_q;
  frws_pkg::out_t            out_data_q;
  frws_pkg::seq_state_t      state_q;
  frws_pkg::seq_state_t      state_d;
  frws_pkg::tbl_wr_t         tbl_wr;
  frws_pkg::out_t            result;
  logic                      cur_slot;
  logic [frws_pkg::SeqW-1:0] cur_seq;
  logic                      advance;
  logic                      fire;

  assign advance    = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && advance;
  assign in_stall_o = in_valid_q && !advance;

  frws_table u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_idx_i  (state_q.active_file),
    .rd_slot_o (cur_slot),
    .rd_seq_o  (cur_seq),
    .wr_i      (tbl_wr)
  );

  frws_step u_step (
    .fire_i     (fire),
    .req_i      (in_data_q),
    .state_q_i  (state_q),
    .cur_slot_i (cur_slot),
    .cur_seq_i  (cur_seq),
    .state_d_o  (state_d),
    .tbl_wr_o   (tbl_wr),
    .result_o   (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_data_q <= in_data_i;
    end
    if (fire) begin
      out_data_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_stall_holds_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !advance) |=> in_valid_q)
    else $error("request dropped while result side stalled");

  a_reject_no_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_data_q.start_rejected && out_data_q.flash_op != frws_pkg::OpNone))
    else $error("rejected request issued a flash operation");

  a_program_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_data_q.flash_op == frws_pkg::OpProgram) |->
      (out_data_q.write_length != '0 &&
       32'(out_data_q.write_length) <= 32'(frws_pkg::PageBytes)))
    else $error("page write length out of range");

  a_idle_no_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && state_d.phase == frws_pkg::PhIdle) |=> (out_valid_q && !out_data_q.sequencer_busy))
    else $error("busy flag disagrees with sequencer phase");

endmodule

[hw/rtl/frws_table.sv]
// File table: current block select and sequence number per file.
`timescale 1ns / 1ps

module frws_table (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [frws_pkg::FileW-1:0]     rd_idx_i,
  output logic                           rd_slot_o,
  output logic [frws_pkg::SeqW-1:0]      rd_seq_o,
  input  frws_pkg::tbl_wr_t              wr_i
);

  logic                        slot_q [frws_pkg::NumFiles];
  logic [frws_pkg::SeqW-1:0]   seq_q  [frws_pkg::NumFiles];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < frws_pkg::NumFiles; i++) begin
        slot_q[i] <= 1'b0;
        seq_q[i]  <= '0;
      end
    end else begin
      if (wr_i.slot_we) begin
        slot_q[wr_i.idx] <= wr_i.slot;
      end
      if (wr_i.seq_we) begin
        seq_q[wr_i.idx] <= wr_i.seq;
      end
    end
  end

  assign rd_slot_o = slot_q[rd_idx_i];
  assign rd_seq_o  = seq_q[rd_idx_i];

endmodule

[hw/rtl/frws_step.sv]
// One request step: next sequencer state, table update and result.
`timescale 1ns / 1ps

module frws_step (
  input  logic                         fire_i,
  input  frws_pkg::in_t                req_i,
  input  frws_pkg::seq_state_t         state_q_i,
  input  logic                         cur_slot_i,
  input  logic [frws_pkg::SeqW-1:0]    cur_seq_i,
  output frws_pkg::seq_state_t         state_d_o,
  output frws_pkg::tbl_wr_t            tbl_wr_o,
  output frws_pkg::out_t               result_o
);

  localparam int BlockW = frws_pkg::BlockW;
  localparam int PageW  = frws_pkg::PageW;
  localparam int AddrW  = frws_pkg::AddrW;
  localparam int FileW  = frws_pkg::FileW;

  logic                 in_range;
  logic                 cmd_ok;
  logic [frws_pkg::SizeW-1:0] clamp_size;
  frws_pkg::phase_e     ph_sent;
  logic                 write_done;
  logic                 erase_done;
  logic                 more_pages;
  logic [AddrW-1:0]     erase_addr;
  logic [BlockW:0]      total;
  logic [BlockW:0]      last_byte;
  logic [BlockW-1:0]    first_off;
  logic [frws_pkg::LenW-1:0] first_len;
  logic [AddrW-1:0]     first_addr;
  logic [frws_pkg::SeqW-1:0] new_seq;
  logic [BlockW-1:0]    page_off;
  logic [BlockW-1:0]    next_off;
  logic [AddrW-1:0]     next_addr;

  assign in_range   = 32'(req_i.file_index) < 32'(frws_pkg::NumFiles);
  assign cmd_ok     = (state_q_i.phase == frws_pkg::PhIdle) && in_range;
  assign clamp_size = (32'(req_i.payload_bytes) > 32'(frws_pkg::MaxSize)) ?
                      frws_pkg::SizeW'(frws_pkg::MaxSize) : req_i.payload_bytes;

  always_comb begin
    ph_sent = state_q_i.phase;
    if (state_q_i.phase == frws_pkg::PhWriteSend && req_i.spi_done) begin
      ph_sent = frws_pkg::PhWriteWait;
    end else if (state_q_i.phase == frws_pkg::PhEraseSend && req_i.spi_done) begin
      ph_sent = frws_pkg::PhEraseWait;
    end
  end

  assign write_done = (ph_sent == frws_pkg::PhWriteWait) && !req_i.flash_busy;
  assign erase_done = (ph_sent == frws_pkg::PhEraseWait) && !req_i.flash_busy;

  assign erase_addr = AddrW'({state_q_i.active_file, ~cur_slot_i, {BlockW{1'b0}}});
  assign total      = (BlockW+1)'(state_q_i.pending_size) + (BlockW+1)'(frws_pkg::HdrBytes);
  assign last_byte  = total - (BlockW+1)'(1);
  assign first_off  = {last_byte[BlockW-1:PageW], {PageW{1'b0}}};
  assign first_len  = frws_pkg::LenW'(total - {1'b0, first_off});
  assign first_addr = erase_addr | AddrW'(first_off);
  assign new_seq    = cur_seq_i + frws_pkg::SeqW'(1);
  assign page_off   = state_q_i.page_address[BlockW-1:0];
  assign more_pages = page_off >= BlockW'(frws_pkg::PageBytes);
  assign next_off   = page_off - BlockW'(frws_pkg::PageBytes);
  assign next_addr  = state_q_i.page_address - AddrW'(frws_pkg::PageBytes);

  // next state
  always_comb begin
    state_d_o = state_q_i;
    if (fire_i) begin
      unique case (req_i.command)
        frws_pkg::CmdStart: begin
          if (cmd_ok) begin
            state_d_o.phase        = frws_pkg::PhEraseIssue;
            state_d_o.active_file  = FileW'(req_i.file_index);
            state_d_o.pending_size = clamp_size;
          end
        end
        frws_pkg::CmdPoll: begin
          unique case (state_q_i.phase)
            frws_pkg::PhIdle: begin
            end
            frws_pkg::PhEraseIssue: begin
              state_d_o.phase        = frws_pkg::PhEraseSend;
              state_d_o.page_address = erase_addr;
            end
            frws_pkg::PhWriteStart: begin
              state_d_o.phase        = frws_pkg::PhWriteSend;
              state_d_o.page_address = first_addr;
            end
            default: begin
              if (write_done) begin
                if (more_pages) begin
                  state_d_o.phase        = frws_pkg::PhWriteSend;
                  state_d_o.page_address = next_addr;
                end else begin
                  state_d_o.phase = frws_pkg::PhIdle;
                end
              end else if (erase_done) begin
                state_d_o.phase = frws_pkg::PhWriteStart;
              end else begin
                state_d_o.phase = ph_sent;
              end
            end
          endcase
        end
        default: begin
        end
      endcase
    end
  end

  // result and table update
  always_comb begin
    result_o          = '0;
    result_o.flash_op = frws_pkg::OpNone;
    tbl_wr_o          = '0;
    if (fire_i) begin
      unique case (req_i.command)
        frws_pkg::CmdStart: begin
          result_o.start_rejected = !cmd_ok;
        end
        frws_pkg::CmdLoad: begin
          result_o.start_rejected = !cmd_ok;
          if (cmd_ok) begin
            tbl_wr_o.slot_we = 1'b1;
            tbl_wr_o.seq_we  = 1'b1;
            tbl_wr_o.idx     = FileW'(req_i.file_index);
            tbl_wr_o.slot    = req_i.load_slot;
            tbl_wr_o.seq     = req_i.load_sequence;
          end
        end
        frws_pkg::CmdPoll: begin
          unique case (state_q_i.phase)
            frws_pkg::PhIdle: begin
            end
            frws_pkg::PhEraseIssue: begin
              result_o.flash_op      = frws_pkg::OpErase;
              result_o.flash_address = erase_addr;
            end
            frws_pkg::PhWriteStart: begin
              result_o.flash_op        = frws_pkg::OpProgram;
              result_o.flash_address   = first_addr;
              result_o.write_length    = first_len;
              result_o.record_offset   = first_off;
              result_o.header_sequence = new_seq;
              result_o.header_checksum = frws_pkg::header_sum(new_seq,
                                                              state_q_i.pending_size);
              tbl_wr_o.seq_we = 1'b1;
              tbl_wr_o.idx    = state_q_i.active_file;
              tbl_wr_o.seq    = new_seq;
            end
            default: begin
              if (write_done) begin
                if (more_pages) begin
                  result_o.flash_op      = frws_pkg::OpProgram;
                  result_o.flash_address = next_addr;
                  result_o.write_length  = frws_pkg::LenW'(frws_pkg::PageBytes);
                  result_o.record_offset = next_off;
                end else begin
                  tbl_wr_o.slot_we = 1'b1;
                  tbl_wr_o.idx     = state_q_i.active_file;
                  tbl_wr_o.slot    = ~cur_slot_i;
                end
              end
            end
          endcase
        end
        default: begin
        end
      endcase
    end
    result_o.sequencer_busy = state_d_o.phase != frws_pkg::PhIdle;
  end

endmodule
